/* src/tea_pkg.sv */
// ----------------------------------------------------------------------------
// tea_pkg
// Types, constants and the round sum function shared by the TEA cipher files.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SHIFT_L    = 4;
  localparam int unsigned SHIFT_R    = 5;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_D = 2'd3;

  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } tea_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } tea_key_t;

  // delta times n, modulo 2^32
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(n);
    return prod[WORD_W-1:0];
  endfunction

endpackage

/* src/tea_block_cipher.sv */
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA block cipher, encrypt or decrypt, as a fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// The pipeline has one stage per half-round, 2*ROUNDS stages in all (64 with
// the default of 32 rounds), and a new block can be taken every cycle while
// the input is not held off. Each stage holds its word unless the next
// stage can take it, so a stalled output fills the empty stages before the
// input is held off. The key words are read directly by every stage: write
// them only while no block is in flight.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [tea_pkg::WORD_W-1:0]          in_first_half,
  input  logic [tea_pkg::WORD_W-1:0]          in_second_half,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tea_pkg::WORD_W-1:0]          out_first_result,
  output logic [tea_pkg::WORD_W-1:0]          out_second_result
);
  import tea_pkg::*;

  localparam int unsigned NSTAGE = 2 * ROUNDS;

  tea_key_t  key_r;
  tea_word_t stage_word [0:NSTAGE];
  logic      stage_valid[0:NSTAGE];
  logic      stage_ready[0:NSTAGE];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_A: key_r.a <= cfg_data;
        REG_KEY_B: key_r.b <= cfg_data;
        REG_KEY_C: key_r.c <= cfg_data;
        REG_KEY_D: key_r.d <= cfg_data;
        default:   key_r   <= key_r;
      endcase
    end
  end

  assign stage_valid[0]  = in_valid;
  assign in_ready        = stage_ready[0];
  assign stage_word[0].dec = in_opcode;
  assign stage_word[0].y   = in_first_half;
  assign stage_word[0].z   = in_second_half;

  for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
    localparam int unsigned RND = j / 2;
    tea_round #(
      .ENC_SUM   (round_sum(RND + 1)),
      .DEC_SUM   (round_sum(ROUNDS - RND)),
      .UPD_Y_ENC ((j % 2) == 0)
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .key       (key_r),
      .in_valid  (stage_valid[j]),
      .in_ready  (stage_ready[j]),
      .in_word   (stage_word[j]),
      .out_valid (stage_valid[j+1]),
      .out_ready (stage_ready[j+1]),
      .out_word  (stage_word[j+1])
    );
  end

  assign stage_ready[NSTAGE] = out_ready;
  assign out_valid           = stage_valid[NSTAGE];
  assign out_first_result    = stage_word[NSTAGE].y;
  assign out_second_result   = stage_word[NSTAGE].z;

endmodule

/* src/tea_round.sv */
// ----------------------------------------------------------------------------
// tea_round
// One half-round pipeline stage: updates one half of the block from the other
// and holds the word in a register with its valid bit.
// ----------------------------------------------------------------------------
module tea_round #(
  parameter logic [31:0] ENC_SUM   = 32'h0,
  parameter logic [31:0] DEC_SUM   = 32'h0,
  parameter bit          UPD_Y_ENC = 1'b1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tea_pkg::tea_key_t  key,
  input  logic               in_valid,
  output logic               in_ready,
  input  tea_pkg::tea_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output tea_pkg::tea_word_t out_word
);
  import tea_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  tea_word_t         word_r;
  tea_word_t         word_nxt;
  logic              upd_y;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] k_lo;
  logic [WORD_W-1:0] k_hi;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] res;

  always_comb begin
    upd_y = UPD_Y_ENC ^ in_word.dec;
    src   = upd_y ? in_word.z : in_word.y;
    dst   = upd_y ? in_word.y : in_word.z;
    k_lo  = upd_y ? key.a : key.c;
    k_hi  = upd_y ? key.b : key.d;
    sum   = in_word.dec ? DEC_SUM : ENC_SUM;
    mix   = ((src << SHIFT_L) + k_lo) ^ (src + sum) ^ ((src >> SHIFT_R) + k_hi);
    res   = in_word.dec ? (dst - mix) : (dst + mix);

    word_nxt     = in_word;
    word_nxt.y   = upd_y ? res : in_word.y;
    word_nxt.z   = upd_y ? in_word.z : res;
  end

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule
